>>> design/mqtt_connect_packet_parser_macros.svh
// assertion macros for the mqtt connect packet parser
// used by the top level only, expects clk and rst_n in scope
`ifndef MQTT_CONNECT_PACKET_PARSER_MACROS_SVH
`define MQTT_CONNECT_PACKET_PARSER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MCP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcp assertion failed");

// antecedent implies consequent in the next cycle
`define MCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcp assertion failed");

`endif

>>> design/mcp_pkg.sv
// shared types, codes and phase helpers for the mqtt connect packet parser
// no dependencies
package mcp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [3:0]  field_kind;
    logic [1:0]  parse_status;
    logic [15:0] keep_alive_seconds;
    logic        clean_session_flag;
    logic [7:0]  protocol_level_out;
    logic        end_of_packet;
  } out_t;

  // request as classified by the front end
  typedef struct packed {
    in_t  req;
    logic byte_zero;
  } front_item_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] KIND_LEN      = 4'd0;
  localparam logic [3:0] KIND_NAME     = 4'd1;
  localparam logic [3:0] KIND_LEVEL    = 4'd2;
  localparam logic [3:0] KIND_FLAGS    = 4'd3;
  localparam logic [3:0] KIND_KEEPALIVE = 4'd4;
  localparam logic [3:0] KIND_CLIENT   = 4'd5;
  localparam logic [3:0] KIND_USER     = 4'd6;
  localparam logic [3:0] KIND_PASS     = 4'd7;
  localparam logic [3:0] KIND_IGNORED  = 4'd8;

  localparam logic [1:0] ST_BUSY      = 2'd0;
  localparam logic [1:0] ST_OK        = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  localparam logic [7:0] FLAG_CLEAN = 8'h02;
  localparam logic [7:0] FLAG_USER  = 8'h80;
  localparam logic [7:0] FLAG_PASS  = 8'h40;

  typedef enum logic [12:0] {
    PH_NAME_LEN = 13'b0000000000001,
    PH_NAME     = 13'b0000000000010,
    PH_LEVEL    = 13'b0000000000100,
    PH_FLAGS    = 13'b0000000001000,
    PH_KA_HI    = 13'b0000000010000,
    PH_KA_LO    = 13'b0000000100000,
    PH_CID_LEN  = 13'b0000001000000,
    PH_CID      = 13'b0000010000000,
    PH_USER_LEN = 13'b0000100000000,
    PH_USER     = 13'b0001000000000,
    PH_PASS_LEN = 13'b0010000000000,
    PH_PASS     = 13'b0100000000000,
    PH_DONE     = 13'b1000000000000
  } phase_t;

  // string phase that follows a length phase
  function automatic phase_t string_phase(input phase_t ph);
    phase_t res;
    res = PH_DONE;
    unique case (ph)
      PH_NAME_LEN: res = PH_NAME;
      PH_CID_LEN:  res = PH_CID;
      PH_USER_LEN: res = PH_USER;
      PH_PASS_LEN: res = PH_PASS;
      default:     res = PH_DONE;
    endcase
    return res;
  endfunction

  // phase after the end of a string, gated by the connect flags
  function automatic phase_t after_string(input phase_t ph, input logic [7:0] flags);
    phase_t res;
    res = PH_DONE;
    priority if (ph == PH_NAME) begin
      res = PH_LEVEL;
    end else if (ph == PH_CID) begin
      if ((flags & FLAG_USER) != 8'h00) begin
        res = PH_USER_LEN;
      end else if ((flags & FLAG_PASS) != 8'h00) begin
        res = PH_PASS_LEN;
      end else begin
        res = PH_DONE;
      end
    end else if (ph == PH_USER) begin
      res = ((flags & FLAG_PASS) != 8'h00) ? PH_PASS_LEN : PH_DONE;
    end else begin
      res = PH_DONE;
    end
    return res;
  endfunction

endpackage

>>> design/mcp_front.sv
// front end: accepts input requests and predecodes the data byte
// depends on mcp_pkg
module mcp_front import mcp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_item,
  output logic        fr_valid,
  input  logic        fr_ready,
  output front_item_t fr_item
);

  logic        valid_r, valid_nxt;
  front_item_t item_r;

  assign in_ready  = !valid_r || fr_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.req       <= in_item;
      item_r.byte_zero <= (in_item.data_byte == 8'h00);
    end
  end

  assign fr_valid = valid_r;
  assign fr_item  = item_r;

endmodule

>>> design/mcp_queue.sv
// short request queue between front end and parser back end
// depends on mcp_pkg
module mcp_queue import mcp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_valid,
  output logic        wr_ready,
  input  front_item_t wr_item,
  output logic        rd_valid,
  input  logic        rd_ready,
  output front_item_t rd_item
);

  localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

  front_item_t                slots_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0]     count_r, count_nxt;
  logic                       push, pop;

  assign wr_ready = (count_r != CNT_FULL);
  assign rd_valid = (count_r != '0);
  assign rd_item  = slots_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

>>> design/mcp_back.sv
// back end: connect packet phase tracking, field labeling and result register
// depends on mcp_pkg
module mcp_back import mcp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  front_item_t q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_item
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [7:0]  high_r, high_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [15:0] keep_alive_r, keep_alive_nxt;
  logic [7:0]  level_r, level_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_item_r;
  out_t        result;
  logic [3:0]  kind;
  logic [15:0] remain_dec;
  logic        take;

  assign q_ready       = !out_valid_r || out_ready;
  assign take          = q_valid && q_ready;
  assign out_valid_nxt = q_ready ? q_valid : out_valid_r;
  assign remain_dec    = remain_r - 16'd1;

  always_comb begin
    phase_nxt      = phase_r;
    remain_nxt     = remain_r;
    high_nxt       = high_r;
    flags_nxt      = flags_r;
    keep_alive_nxt = keep_alive_r;
    level_nxt      = level_r;
    kind           = KIND_IGNORED;
    unique case (phase_r)
      PH_NAME_LEN, PH_CID_LEN, PH_USER_LEN, PH_PASS_LEN: begin
        kind = KIND_LEN;
        if (remain_r == 16'd0) begin
          high_nxt   = q_item.req.data_byte;
          remain_nxt = 16'd1;
        end else begin
          remain_nxt = {high_r, q_item.req.data_byte};
          high_nxt   = 8'h00;
          if (high_r == 8'h00 && q_item.byte_zero) begin
            phase_nxt = after_string(string_phase(phase_r), flags_r);
          end else begin
            phase_nxt = string_phase(phase_r);
          end
        end
      end
      PH_NAME, PH_CID, PH_USER, PH_PASS: begin
        unique case (phase_r)
          PH_NAME: kind = KIND_NAME;
          PH_CID:  kind = KIND_CLIENT;
          PH_USER: kind = KIND_USER;
          default: kind = KIND_PASS;
        endcase
        remain_nxt = remain_dec;
        if (remain_dec == 16'd0) begin
          phase_nxt = after_string(phase_r, flags_r);
        end
      end
      PH_LEVEL: begin
        kind      = KIND_LEVEL;
        level_nxt = q_item.req.data_byte;
        phase_nxt = PH_FLAGS;
      end
      PH_FLAGS: begin
        kind      = KIND_FLAGS;
        flags_nxt = q_item.req.data_byte;
        phase_nxt = PH_KA_HI;
      end
      PH_KA_HI: begin
        kind      = KIND_KEEPALIVE;
        high_nxt  = q_item.req.data_byte;
        phase_nxt = PH_KA_LO;
      end
      PH_KA_LO: begin
        kind           = KIND_KEEPALIVE;
        keep_alive_nxt = {high_r, q_item.req.data_byte};
        high_nxt       = 8'h00;
        remain_nxt     = 16'd0;
        phase_nxt      = PH_CID_LEN;
      end
      default: begin
        kind      = KIND_IGNORED;
        phase_nxt = PH_DONE;
      end
    endcase
  end

  always_comb begin
    result.byte_value         = q_item.req.data_byte;
    result.field_kind         = kind;
    result.parse_status       = !q_item.req.last_byte ? ST_BUSY :
                                (phase_nxt == PH_DONE) ? ST_OK : ST_MALFORMED;
    result.keep_alive_seconds = keep_alive_nxt;
    result.clean_session_flag = ((flags_nxt & FLAG_CLEAN) != 8'h00);
    result.protocol_level_out = level_nxt;
    result.end_of_packet      = q_item.req.last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_NAME_LEN;
      remain_r     <= '0;
      high_r       <= '0;
      flags_r      <= '0;
      keep_alive_r <= '0;
      level_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        if (q_item.req.last_byte) begin
          phase_r      <= PH_NAME_LEN;
          remain_r     <= '0;
          high_r       <= '0;
          flags_r      <= '0;
          keep_alive_r <= '0;
          level_r      <= '0;
        end else begin
          phase_r      <= phase_nxt;
          remain_r     <= remain_nxt;
          high_r       <= high_nxt;
          flags_r      <= flags_nxt;
          keep_alive_r <= keep_alive_nxt;
          level_r      <= level_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> design/mqtt_connect_packet_parser.sv
// top level of the mqtt connect packet parser: front end, queue, back end
// depends on mcp_pkg, mcp_front, mcp_queue, mcp_back and the macros header
//
// Takes the bytes of an MQTT CONNECT packet after the fixed header, one byte
// per request with last_byte on the final one, and returns one result per
// byte labeling its field, with the keep-alive, clean session flag and level
// seen so far; the result for the last byte carries ok or malformed and the
// parser then starts over for the next packet. One byte per cycle is
// sustained in both directions while the result side does not stall. On its way
// from acceptance to its result a byte passes the front end register, an entry
// of the two-entry queue and the parser's result register. With the result side
// stalled, the front end register, the two queue entries and the result
// register hold up to four bytes before the input is held off.
`include "mqtt_connect_packet_parser_macros.svh"

module mqtt_connect_packet_parser import mcp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_item,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_item
);

  logic        fr_valid, fr_ready;
  front_item_t fr_item;
  logic        q_valid, q_ready;
  front_item_t q_item;
  logic        res_mid, res_end, res_stall, status_final;

  mcp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready),
    .fr_item  (fr_item)
  );

  mcp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_item  (fr_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  mcp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  assign res_mid      = out_valid && !out_item.end_of_packet;
  assign res_end      = out_valid && out_item.end_of_packet;
  assign res_stall    = out_valid && !out_ready;
  assign status_final = (out_item.parse_status == ST_OK) ||
                        (out_item.parse_status == ST_MALFORMED);

  // status only on the closing byte of a packet
  `MCP_ASSERT_IMPLY(a_busy_mid_packet, res_mid, out_item.parse_status == ST_BUSY)
  `MCP_ASSERT_IMPLY(a_final_status, res_end, status_final)
  // a stalled result holds still
  `MCP_ASSERT_NEXT(a_hold_while_stalled, res_stall, out_valid && $stable(out_item))

endmodule

>>> test/mcp_result_checker.sv
// result checker for the mqtt connect packet parser: predicts every result from the
// accepted requests and compares it with what the parser returns
// depends on mcp_pkg for the channel structs, field kinds, status codes and phases
`timescale 1ns / 100ps

module mcp_result_checker import mcp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_item,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_item,
  output int   fail_count,
  output int   pending_count
);

  out_t        expected_results[$];

  phase_t      cur_phase;
  logic [15:0] str_left;
  logic [7:0]  len_hi;
  logic [7:0]  flag_bits;
  logic [15:0] ka_value;
  logic [7:0]  level_seen;

  task automatic clear_parse();
    cur_phase  = PH_NAME_LEN;
    str_left   = 16'd0;
    len_hi     = 8'd0;
    flag_bits  = 8'd0;
    ka_value   = 16'd0;
    level_seen = 8'd0;
  endtask

  function automatic phase_t body_phase(input phase_t len_ph);
    case (len_ph)
      PH_NAME_LEN: return PH_NAME;
      PH_CID_LEN:  return PH_CID;
      PH_USER_LEN: return PH_USER;
      default:     return PH_PASS;
    endcase
  endfunction

  function automatic phase_t phase_after_string(input phase_t str_ph);
    if (str_ph == PH_NAME) return PH_LEVEL;
    if (str_ph == PH_CID && flag_bits[7]) return PH_USER_LEN;
    if ((str_ph == PH_CID || str_ph == PH_USER) && flag_bits[6]) return PH_PASS_LEN;
    return PH_DONE;
  endfunction

  task automatic parse_byte(input in_t req, output out_t res);
    logic [3:0] kind;
    phase_t     sp;
    kind = KIND_IGNORED;
    case (cur_phase)
      PH_NAME_LEN, PH_CID_LEN, PH_USER_LEN, PH_PASS_LEN: begin
        kind = KIND_LEN;
        if (str_left == 16'd0) begin
          len_hi   = req.data_byte;
          str_left = 16'd1;
        end else begin
          str_left = {len_hi, req.data_byte};
          len_hi   = 8'd0;
          sp = body_phase(cur_phase);
          cur_phase = (str_left == 16'd0) ? phase_after_string(sp) : sp;
        end
      end
      PH_NAME, PH_CID, PH_USER, PH_PASS: begin
        case (cur_phase)
          PH_NAME: kind = KIND_NAME;
          PH_CID:  kind = KIND_CLIENT;
          PH_USER: kind = KIND_USER;
          default: kind = KIND_PASS;
        endcase
        str_left = str_left - 16'd1;
        if (str_left == 16'd0) cur_phase = phase_after_string(cur_phase);
      end
      PH_LEVEL: begin
        kind       = KIND_LEVEL;
        level_seen = req.data_byte;
        cur_phase  = PH_FLAGS;
      end
      PH_FLAGS: begin
        kind      = KIND_FLAGS;
        flag_bits = req.data_byte;
        cur_phase = PH_KA_HI;
      end
      PH_KA_HI: begin
        kind      = KIND_KEEPALIVE;
        len_hi    = req.data_byte;
        cur_phase = PH_KA_LO;
      end
      PH_KA_LO: begin
        kind      = KIND_KEEPALIVE;
        ka_value  = {len_hi, req.data_byte};
        len_hi    = 8'd0;
        str_left  = 16'd0;
        cur_phase = PH_CID_LEN;
      end
      default: begin
        kind      = KIND_IGNORED;
        cur_phase = PH_DONE;
      end
    endcase
    res.byte_value         = req.data_byte;
    res.field_kind         = kind;
    res.parse_status       = !req.last_byte ? ST_BUSY :
                             (cur_phase == PH_DONE) ? ST_OK : ST_MALFORMED;
    res.keep_alive_seconds = ka_value;
    res.clean_session_flag = (flag_bits & FLAG_CLEAN) != 8'h00;
    res.protocol_level_out = level_seen;
    res.end_of_packet      = req.last_byte;
    if (req.last_byte) clear_parse();
  endtask

  task automatic check_field(input string name, input logic [15:0] exp, input logic [15:0] got);
    if (got !== exp) begin
      $error("%s expected %0h got %0h", name, exp, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_t exp_res;
    out_t new_res;
    if (!rst_n) begin
      clear_parse();
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(in_item, new_res);
        expected_results = {expected_results, new_res};
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request pending");
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("byte_value", 16'(exp_res.byte_value), 16'(out_item.byte_value));
          check_field("field_kind", 16'(exp_res.field_kind), 16'(out_item.field_kind));
          check_field("parse_status", 16'(exp_res.parse_status),
                      16'(out_item.parse_status));
          check_field("keep_alive_seconds", exp_res.keep_alive_seconds,
                      out_item.keep_alive_seconds);
          check_field("clean_session_flag", 16'(exp_res.clean_session_flag),
                      16'(out_item.clean_session_flag));
          check_field("protocol_level_out", 16'(exp_res.protocol_level_out),
                      16'(out_item.protocol_level_out));
          check_field("end_of_packet", 16'(exp_res.end_of_packet),
                      16'(out_item.end_of_packet));
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

>>> test/tb_top.sv
// top of the mqtt connect packet parser testbench: clock, reset, packet stimulus with
// bursty sending and receiver stalls, and the final verdict
// depends on mcp_pkg, mqtt_connect_packet_parser and mcp_result_checker
`timescale 1ns / 100ps

module tb_top;
  import mcp_pkg::*;

  localparam int RANDOM_BYTES = 750;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_item   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_item;
  int   fail_count;
  int   pending_count;

  in_t  pkt[$];
  int   burst_left = 0;
  int   sent_count = 0;
  int   cycle_count = 0;

  mqtt_connect_packet_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  mcp_result_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stall pattern
  initial begin
    int n;
    forever begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      repeat (n) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
      n = $urandom_range(1, 8);
      repeat (n) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic add_byte(input logic [7:0] b);
    in_t req;
    req.data_byte = b;
    req.last_byte = 1'b0;
    pkt = {pkt, req};
  endtask

  task automatic add_string(input int n);
    add_byte(n[15:8]);
    add_byte(n[7:0]);
    repeat (n) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic mark_last();
    pkt[pkt.size() - 1].last_byte = 1'b1;
  endtask

  task automatic build_connect(input bit cut);
    logic [7:0] flags;
    int k;
    pkt.delete();
    add_string(($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 4);
    add_byte(8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 8'h04));
    flags = 8'($urandom_range(0, 255));
    add_byte(flags);
    add_byte(8'($urandom_range(0, 255)));
    add_byte(8'($urandom_range(0, 255)));
    add_string($urandom_range(0, 8));
    if ((flags & FLAG_USER) != 8'h00) add_string($urandom_range(0, 6));
    if ((flags & FLAG_PASS) != 8'h00) add_string($urandom_range(0, 6));
    repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
    if (cut) begin
      k = $urandom_range(1, pkt.size());
      while (pkt.size() > k) pkt.delete(pkt.size() - 1);
    end
    mark_last();
  endtask

  task automatic build_noise();
    pkt.delete();
    repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
    mark_last();
  endtask

  // sender works in bursts with random gaps between them
  task automatic send_packet();
    int gap;
    foreach (pkt[i]) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100) :
                     $urandom_range(1, 12);
      end
      in_valid <= 1'b1;
      in_item  <= pkt[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      burst_left--;
      sent_count++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int  pick;
    bit  paused;
    paused = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // early end on the very first byte
    pkt.delete();
    add_byte(8'hFF);
    mark_last();
    send_packet();

    // empty name and client id, extreme level and keep-alive, clean session
    pkt.delete();
    add_byte(8'h00); add_byte(8'h00);
    add_byte(8'hFF); add_byte(FLAG_CLEAN);
    add_byte(8'hFF); add_byte(8'hFF);
    add_byte(8'h00); add_byte(8'h00);
    mark_last();
    send_packet();

    // username and password present, empty username, trailing byte
    pkt.delete();
    add_byte(8'h00); add_byte(8'h01); add_byte(8'h4D);
    add_byte(8'h00); add_byte(FLAG_USER | FLAG_PASS);
    add_byte(8'h00); add_byte(8'h00);
    add_byte(8'h00); add_byte(8'h00);
    add_byte(8'h00); add_byte(8'h00);
    add_byte(8'h00); add_byte(8'h01); add_byte(8'hAA);
    add_byte(8'h00);
    mark_last();
    send_packet();
    wait_drained();

    sent_count = 0;
    while (sent_count < RANDOM_BYTES) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) build_connect(1'b0);
      else if (pick < 9) build_connect(1'b1);
      else build_noise();
      send_packet();
      if (!paused && sent_count >= RANDOM_BYTES / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (12) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
